// ----- rtl/pip_pkg.sv -----
package pip_pkg;

    localparam int MIN_POLY_VERTICES = 3;
    localparam int CFG_BITS          = 5;
    localparam int INDEX_BITS        = 4;

    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_query;   // latch query point, clear parity
        logic wr_vertex;    // write one vertex into the store
        logic rd_en;        // read one vertex for the edge walk
        logic rd_first;     // first read of the walk, no edge yet
        logic finish;       // register the result
    } pip_cmd_t;

endpackage

// ----- rtl/point_in_polygon_test.sv -----
// Ray-casting point-in-polygon tester. Vertices are written one per transaction
// with mode low; busy stays low and no result is given. A query (mode high) gives
// one result strobe; for a polygon of n >= 3 vertices it keeps busy high while
// the vertex store is read once per edge through its one read port (n reads
// plus one more for the closing edge) and a three-stage difference, multiply
// and compare pipeline drains; result_valid rises as busy falls. With fewer
// than 3 vertices the edge walk is skipped and the result follows directly.
// A new transaction may be started in the cycle the result is shown.
// Results are held for exactly one cycle and cannot be stalled, so the receiver
// must take every strobe. num_vertices is written through cfg_valid/cfg_data
// while busy and start are low.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [pip_pkg::INDEX_BITS-1:0]    vertex_index,
    input  logic signed [COORD_BITS-1:0]      coord_x,
    input  logic signed [COORD_BITS-1:0]      coord_y,
    input  logic                              last_point,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pip_pkg::CFG_BITS-1:0]      cfg_data,
    output logic                              result_valid,
    output logic                              point_inside,
    output logic                              any_inside,
    output logic                              run_end
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    pip_cmd_t      cmd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .vertex_index (vertex_index),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .busy         (busy),
        .cfg_ready    (cfg_ready),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .last_point   (last_point),
        .result_valid (result_valid),
        .point_inside (point_inside),
        .any_inside   (any_inside),
        .run_end      (run_end)
    );

endmodule

// ----- rtl/pip_ctrl.sv -----
module pip_ctrl #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               mode,
    input  logic [pip_pkg::INDEX_BITS-1:0]     vertex_index,
    input  logic                               cfg_valid,
    input  logic [pip_pkg::CFG_BITS-1:0]       cfg_data,
    output logic                               busy,
    output logic                               cfg_ready,
    output pip_pkg::pip_cmd_t                  cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]    rd_addr,
    output logic [$clog2(MAX_VERTICES)-1:0]    wr_addr
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // last drain count, while the compare pipeline empties after the last read
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [1:0]          drain_reg, drain_next;
    logic [CFG_BITS-1:0] num_vertices_reg;
    logic [CW-1:0]       n_eff;
    logic                small_poly;
    logic                accept;

    always_comb
    begin
        if (int'(num_vertices_reg) > MAX_VERTICES)
        begin
            n_eff = CW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = CW'(num_vertices_reg);
        end
    end

    assign small_poly = int'(num_vertices_reg) < MIN_POLY_VERTICES;
    assign busy       = state_reg != ST_IDLE;
    // the count may only change between transactions
    assign cfg_ready  = !busy && !start;
    assign accept     = start && !busy;
    assign wr_addr    = AW'(vertex_index);
    // the walk ends by reading vertex 0 again for the closing edge
    assign rd_addr    = (cnt_reg == n_eff) ? '0 : cnt_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drain_next = drain_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_VERTEX)
                begin
                    cmd.wr_vertex = int'(vertex_index) < MAX_VERTICES;
                end
                else if (accept)
                begin
                    cmd.load_query = 1'b1;
                    cnt_next       = '0;
                    state_next     = small_poly ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = cnt_reg == '0;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == n_eff)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            drain_reg        <= '0;
            num_vertices_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drain_reg <= drain_next;
            if (cfg_valid && cfg_ready)
            begin
                num_vertices_reg <= cfg_data;
            end
        end
    end

    a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_QUERY) |=> busy)
        else $error("query transaction did not start a walk");

    a_vertex_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_VERTEX) |=> !busy)
        else $error("vertex transaction left the block busy");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cnt_reg <= n_eff && !small_poly))
        else $error("edge walk ran past the vertex count");

    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !cmd.finish)
        else $error("result registered twice");

endmodule

// ----- rtl/pip_datapath.sv -----
module pip_datapath #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pip_pkg::pip_cmd_t                    cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]      rd_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0]      wr_addr,
    input  logic signed [COORD_BITS-1:0]         coord_x,
    input  logic signed [COORD_BITS-1:0]         coord_y,
    input  logic                                 last_point,
    output logic                                 result_valid,
    output logic                                 point_inside,
    output logic                                 any_inside,
    output logic                                 run_end
);
    import pip_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic                         last_reg;
    logic signed [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                         s1_valid_reg, s1_first_reg;

    logic signed [DW-1:0]         a_reg, dy_reg, b_reg, c_reg;
    logic signed [DW-1:0]         a_next, dy_next, b_next, c_next;
    logic                         s2_cross_reg, s2_dy_pos_reg;
    logic                         straddle;

    logic signed [PW-1:0]         lhs_reg, rhs_reg;
    logic signed [PW-1:0]         lhs_next, rhs_next;
    logic                         s3_cross_reg, s3_dy_pos_reg;
    logic                         hit;

    logic                         parity_reg, run_any_reg;
    logic                         any_next;
    logic                         result_valid_reg, point_inside_reg;
    logic                         any_inside_reg, run_end_reg;

    // vertex store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_vertex)
        begin
            mem_x[wr_addr] <= coord_x;
            mem_y[wr_addr] <= coord_y;
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    // edge (prev, current): differences and straddle test
    assign straddle = (prev_y_reg > py_reg) != (rd_y_reg > py_reg);
    assign a_next   = DW'(px_reg) - DW'(prev_x_reg);
    assign dy_next  = DW'(rd_y_reg) - DW'(prev_y_reg);
    assign b_next   = DW'(rd_x_reg) - DW'(prev_x_reg);
    assign c_next   = DW'(py_reg) - DW'(prev_y_reg);

    assign lhs_next = PW'(a_reg) * PW'(dy_reg);
    assign rhs_next = PW'(b_reg) * PW'(c_reg);

    // sign fix: the inequality flips when dy is negative
    assign hit      = s3_dy_pos_reg ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg);
    assign any_next = run_any_reg | parity_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            px_reg   <= coord_x;
            py_reg   <= coord_y;
            last_reg <= last_point;
        end
        if (s1_valid_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        a_reg         <= a_next;
        dy_reg        <= dy_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        s2_dy_pos_reg <= dy_next > 0;
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        s3_dy_pos_reg <= s2_dy_pos_reg;
        if (cmd.finish)
        begin
            point_inside_reg <= parity_reg;
            any_inside_reg   <= any_next;
            run_end_reg      <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s1_first_reg     <= 1'b0;
            s2_cross_reg     <= 1'b0;
            s3_cross_reg     <= 1'b0;
            parity_reg       <= 1'b0;
            run_any_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= cmd.rd_en;
            s1_first_reg     <= cmd.rd_first;
            s2_cross_reg     <= s1_valid_reg && !s1_first_reg && straddle;
            s3_cross_reg     <= s2_cross_reg;
            result_valid_reg <= cmd.finish;
            if (cmd.load_query)
            begin
                parity_reg <= 1'b0;
            end
            else if (s3_cross_reg && hit)
            begin
                parity_reg <= !parity_reg;
            end
            if (cmd.finish)
            begin
                run_any_reg <= last_reg ? 1'b0 : any_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign point_inside = point_inside_reg;
    assign any_inside   = any_inside_reg;
    assign run_end      = run_end_reg;

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held longer than one cycle");

    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && run_end_reg) |-> !run_any_reg)
        else $error("run flag survived the end of a run");

endmodule
